// ----- hw/rtl/mux_frame_varint_encoder_core_assert.svh -----
// Assertion macros for the frame encoder.
`ifndef MUX_FRAME_VARINT_ENCODER_CORE_ASSERT_SVH
`define MUX_FRAME_VARINT_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define MFVE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfve assertion failed");

// Next-cycle implication, checked out of reset
`define MFVE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mfve assertion failed");

`endif

// ----- hw/rtl/mfve_pkg.sv -----
`default_nettype none

package mfve_pkg;

  // Largest payload length that a start item may announce
  localparam int unsigned MAX_PAYLOAD = 1048576;

  localparam int unsigned ID_W   = 61;
  localparam int unsigned FLAG_W = 3;
  localparam int unsigned LEN_W  = 21;
  localparam int unsigned HDR_W  = ID_W + FLAG_W;
  localparam int unsigned BYTE_W = 8;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // What the serialiser is currently emitting
  typedef enum logic [1:0] {
    KIND_PAYLOAD,
    KIND_HEADER,
    KIND_LENGTH
  } kind_t;

  // Work handed from the input stage to the serialiser
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [HDR_W-1:0]  val;
    logic [LEN_W-1:0]  len;
    logic              end_last;
    logic              last;
  } load_t;

  // Serialiser status back to the input stage
  typedef struct packed {
    logic busy;
    logic finishing;
  } ser_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mfve_in_if.sv -----
`default_nettype none

interface mfve_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [mfve_pkg::ID_W-1:0]      chan_id;
  logic [mfve_pkg::FLAG_W-1:0]    frame_flag;
  logic [mfve_pkg::LEN_W-1:0]     payload_len;
  logic                           payload_present;
  logic [mfve_pkg::BYTE_W-1:0]    data_byte;

  modport source (
    output valid, command, chan_id, frame_flag, payload_len, payload_present, data_byte,
    input  ready
  );
  modport sink (
    input  valid, command, chan_id, frame_flag, payload_len, payload_present, data_byte,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/mfve_out_if.sv -----
`default_nettype none

interface mfve_out_if;
  logic                        valid;
  logic                        ready;
  logic [mfve_pkg::BYTE_W-1:0] out_byte;
  logic                        last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mfve_serializer.sv -----
`default_nettype none

module mfve_serializer (
  input  wire                    clk,
  input  wire                    rst,
  input  mfve_pkg::load_t        load,
  output mfve_pkg::ser_status_t  status,
  mfve_out_if.source             dout
);

  // Work register
  logic                           w_busy;
  mfve_pkg::kind_t                w_kind;
  logic [mfve_pkg::HDR_W-1:0]     w_val;
  logic [mfve_pkg::LEN_W-1:0]     w_len;
  logic                           w_end_last;
  logic                           w_last;

  // Result register
  logic                           o_valid;
  logic [mfve_pkg::BYTE_W-1:0]    o_byte;
  logic                           o_last;

  logic                           hi_nz;
  logic [mfve_pkg::BYTE_W-1:0]    e_byte;
  logic                           e_last;
  logic                           e_done;
  logic                           emit;

  // One byte from the work register
  always_comb begin
    hi_nz = |w_val[mfve_pkg::HDR_W-1:7];
    case (w_kind)
      mfve_pkg::KIND_PAYLOAD: begin
        e_byte = w_val[mfve_pkg::BYTE_W-1:0];
        e_last = w_last;
        e_done = 1'b1;
      end
      mfve_pkg::KIND_HEADER: begin
        e_byte = {hi_nz, w_val[6:0]};
        e_last = 1'b0;
        e_done = 1'b0;
      end
      mfve_pkg::KIND_LENGTH: begin
        e_byte = {hi_nz, w_val[6:0]};
        e_last = !hi_nz && w_end_last;
        e_done = !hi_nz;
      end
      default: begin
        e_byte = '0;
        e_last = 1'b0;
        e_done = 1'b1;
      end
    endcase
  end

  assign emit             = w_busy && (!o_valid || dout.ready);
  assign status.busy      = w_busy;
  assign status.finishing = emit && e_done;

  // Work register: load, shift on by seven bits, or move to the length varint
  always_ff @(posedge clk) begin
    if (rst) begin
      w_busy <= 1'b0;
    end else if (load.valid) begin
      w_busy <= 1'b1;
    end else if (emit && e_done) begin
      w_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      w_kind     <= load.kind;
      w_val      <= load.val;
      w_len      <= load.len;
      w_end_last <= load.end_last;
      w_last     <= load.last;
    end else if (emit && !e_done) begin
      if (w_kind == mfve_pkg::KIND_HEADER && !hi_nz) begin
        w_kind <= mfve_pkg::KIND_LENGTH;
        w_val  <= {{(mfve_pkg::HDR_W - mfve_pkg::LEN_W){1'b0}}, w_len};
      end else begin
        w_val  <= w_val >> 7;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (!o_valid || dout.ready) begin
      o_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_byte <= e_byte;
      o_last <= e_last;
    end
  end

  assign dout.valid     = o_valid;
  assign dout.out_byte  = o_byte;
  assign dout.last_byte = o_last;

endmodule

`default_nettype wire

// ----- hw/rtl/mux_frame_varint_encoder_core.sv -----
`default_nettype none

// Frame encoder for a stream multiplexer. A start item (command 0) produces
// the header varint ({chan_id, frame_flag}, 1 to 10 bytes) followed by the
// payload length varint (1 to 3 bytes), one byte per cycle on dout while dout
// is ready; the next item is taken in the cycle the start item's last byte
// moves to the result register. A payload item (command 1) inside an open
// frame passes its byte through the serialiser, so payload streams at one
// item per cycle while dout is ready. The frame's final
// byte carries last_byte. Start items announcing more than MAX_PAYLOAD bytes,
// and payload items with no frame open, are taken and dropped. A new start
// abandons an open frame without marking any byte last.
module mux_frame_varint_encoder_core (
  input  wire        clk,
  input  wire        rst,
  mfve_in_if.sink    din,
  mfve_out_if.source dout
);

`include "mux_frame_varint_encoder_core_assert.svh"

  logic [mfve_pkg::LEN_W-1:0] bytes_left;
  logic [mfve_pkg::LEN_W-1:0] bytes_left_next;
  logic                       frame_open;
  logic                       frame_open_next;

  mfve_pkg::load_t            load;
  mfve_pkg::ser_status_t      status;
  logic                       accept;
  logic                       len_ok;
  logic                       has_payload;

  assign din.ready = !status.busy || status.finishing;
  assign accept    = din.valid && din.ready;

  // Decode the item and update the frame state at acceptance
  always_comb begin
    len_ok          = din.payload_len <= mfve_pkg::MAX_LEN;
    has_payload     = din.payload_present && (din.payload_len != '0);
    bytes_left_next = bytes_left;
    frame_open_next = frame_open;
    load.valid      = 1'b0;
    load.kind       = mfve_pkg::KIND_HEADER;
    load.val        = {din.chan_id, din.frame_flag};
    load.len        = din.payload_len;
    load.end_last   = !has_payload;
    load.last       = 1'b0;
    if (accept) begin
      if (din.command == mfve_pkg::CMD_START) begin
        if (len_ok) begin
          load.valid      = 1'b1;
          frame_open_next = has_payload;
          bytes_left_next = has_payload ? din.payload_len : '0;
        end
      end else if (frame_open && bytes_left != '0) begin
        load.valid      = 1'b1;
        load.kind       = mfve_pkg::KIND_PAYLOAD;
        load.val        = {{(mfve_pkg::HDR_W - mfve_pkg::BYTE_W){1'b0}}, din.data_byte};
        load.last       = (bytes_left == mfve_pkg::LEN_W'(1));
        bytes_left_next = bytes_left - mfve_pkg::LEN_W'(1);
        frame_open_next = (bytes_left != mfve_pkg::LEN_W'(1));
      end else begin
        // stray payload item
        bytes_left_next = '0;
        frame_open_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      frame_open <= 1'b0;
    end else begin
      bytes_left <= bytes_left_next;
      frame_open <= frame_open_next;
    end
  end

  mfve_serializer u_ser (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .status (status),
    .dout   (dout)
  );

  // Checks
  `MFVE_ASSERT_NOW(a_open_has_count, clk, rst, frame_open, bytes_left != '0)
  `MFVE_ASSERT_NOW(a_count_in_range, clk, rst, 1'b1, bytes_left <= mfve_pkg::MAX_LEN)
  `MFVE_ASSERT_NOW(a_no_overrun, clk, rst, status.busy && din.ready, status.finishing)
  `MFVE_ASSERT_NEXT(a_load_busy, clk, rst, load.valid, status.busy)

endmodule

`default_nettype wire
